FILE: rtl/core/blse_pkg.sv
// Shared types and constants for the bounded list with search and erase.
`timescale 1ns / 1ps

package blse_pkg;

   localparam int KIND_W      = 3;
   localparam int DATA_W      = 32;
   localparam int STATUS_W    = 2;
   localparam int COUNT_OUT_W = 5;

   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH   = 3'd0,
      KIND_POP    = 3'd1,
      KIND_MEMBER = 3'd2,
      KIND_ERASE  = 3'd3,
      KIND_CLEAR  = 3'd4
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_UNDERFLOW = 2'd1,
      STATUS_OVERFLOW  = 2'd2
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start_op;
      logic push_wr;
      logic pop;
      logic set_under;
      logic set_over;
      logic clear;
      logic idx_load_top;
      logic idx_load_second;
      logic idx_dec;
      logic idx_inc;
      logic mem_rd;
      logic set_found;
      logic shift_wr;
      logic count_dec;
      logic front_load;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic empty;
      logic full;
      logic match;
      logic idx_zero;
      logic shift_more;
      logic count_gt1;
   } dp_sts_type;

endpackage

FILE: rtl/core/blse_datapath.sv
// Datapath of the bounded list: entry memory, count, front, index and result registers.
`timescale 1ns / 1ps

module blse_datapath #(
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  blse_pkg::dp_cmd_type                   cmd,
   output blse_pkg::dp_sts_type                   sts,
   input  logic signed [blse_pkg::DATA_W-1:0]     req_value,
   output logic signed [blse_pkg::DATA_W-1:0]     popped_value,
   output logic                                   found,
   output logic [blse_pkg::STATUS_W-1:0]          status,
   output logic [blse_pkg::COUNT_OUT_W-1:0]       entry_count,
   output logic signed [blse_pkg::DATA_W-1:0]     front_value,
   output logic                                   is_empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [blse_pkg::DATA_W-1:0] mem [DEPTH];

   logic [CW-1:0]               count_ff, count_in;
   logic [AW-1:0]               idx_ff, idx_in;
   logic [blse_pkg::DATA_W-1:0] front_ff, front_in;
   logic [blse_pkg::DATA_W-1:0] value_ff;
   logic [blse_pkg::DATA_W-1:0] rd_data_ff;
   logic [blse_pkg::DATA_W-1:0] popped_ff, popped_in;
   logic                        found_ff, found_in;
   logic [blse_pkg::STATUS_W-1:0] status_ff, status_in;

   logic [CW-1:0] count_m1;
   logic [CW-1:0] count_m2;
   logic [CW-1:0] idx_p1;
   logic [AW-1:0] idx_m1;
   logic [AW-1:0] wr_addr;
   logic          wr_en;
   logic [blse_pkg::DATA_W-1:0] wr_data;

   assign count_m1 = count_ff - CW'(1);
   assign count_m2 = count_ff - CW'(2);
   assign idx_p1   = CW'(idx_ff) + CW'(1);
   assign idx_m1   = idx_ff - AW'(1);

   assign sts.empty      = (count_ff == '0);
   assign sts.full       = (count_ff == CW'(DEPTH));
   assign sts.match      = (rd_data_ff == value_ff);
   assign sts.idx_zero   = (idx_ff == '0);
   assign sts.shift_more = (idx_p1 < count_ff);
   assign sts.count_gt1  = (count_ff > CW'(1));

   // Push writes at the top of the list; erase moves entries down by one.
   assign wr_en   = cmd.push_wr || cmd.shift_wr;
   assign wr_addr = cmd.push_wr ? count_ff[AW-1:0] : idx_m1;
   assign wr_data = cmd.push_wr ? req_value : rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.mem_rd) begin
         rd_data_ff <= mem[idx_ff];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.clear) begin
         count_in = '0;
      end else if (cmd.push_wr) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.pop || cmd.count_dec) begin
         count_in = count_m1;
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_load_top) begin
         idx_in = count_m1[AW-1:0];
      end else if (cmd.idx_load_second) begin
         idx_in = count_m2[AW-1:0];
      end else if (cmd.idx_dec) begin
         idx_in = idx_m1;
      end else if (cmd.idx_inc) begin
         idx_in = idx_p1[AW-1:0];
      end
   end

   always_comb begin
      front_in = front_ff;
      if (cmd.push_wr) begin
         front_in = req_value;
      end else if (cmd.front_load) begin
         front_in = rd_data_ff;
      end
   end

   always_comb begin
      popped_in = popped_ff;
      found_in  = found_ff;
      status_in = status_ff;
      if (cmd.start_op) begin
         popped_in = '0;
         found_in  = 1'b0;
         status_in = blse_pkg::STATUS_OK;
      end
      if (cmd.pop) begin
         popped_in = front_ff;
      end
      if (cmd.set_found) begin
         found_in = 1'b1;
      end
      if (cmd.set_under) begin
         status_in = blse_pkg::STATUS_UNDERFLOW;
      end else if (cmd.set_over) begin
         status_in = blse_pkg::STATUS_OVERFLOW;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      front_ff  <= front_in;
      popped_ff <= popped_in;
      found_ff  <= found_in;
      status_ff <= status_in;
      if (cmd.start_op) begin
         value_ff <= req_value;
      end
   end

   assign popped_value = popped_ff;
   assign found        = found_ff;
   assign status       = status_ff;
   assign entry_count  = blse_pkg::COUNT_OUT_W'(count_ff);
   assign is_empty     = (count_ff == '0);
   assign front_value  = (count_ff == '0) ? '0 : front_ff;

endmodule

FILE: rtl/core/blse_controller.sv
// Controller state machine that sequences one list operation through the datapath.
`timescale 1ns / 1ps

module blse_controller (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [blse_pkg::KIND_W-1:0]       req_kind,
   input  blse_pkg::dp_sts_type              sts,
   output blse_pkg::dp_cmd_type              cmd,
   output logic                              busy,
   output logic                              rsp_valid
);

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_SRCH_RD  = 8'b0000_0010,
      ST_SRCH_CMP = 8'b0000_0100,
      ST_SHIFT_RD = 8'b0000_1000,
      ST_SHIFT_WR = 8'b0001_0000,
      ST_FRONT_RD = 8'b0010_0000,
      ST_FRONT_LD = 8'b0100_0000,
      ST_RESP     = 8'b1000_0000
   } state_type;

   state_type                     state_ff, state_in;
   logic [blse_pkg::KIND_W-1:0]   kind_ff, kind_in;

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.start_op = 1'b1;
               kind_in      = req_kind;
               state_in     = ST_RESP;
               unique case (req_kind)
                  blse_pkg::KIND_PUSH: begin
                     if (sts.full) begin
                        cmd.set_over = 1'b1;
                     end else begin
                        cmd.push_wr = 1'b1;
                     end
                  end
                  blse_pkg::KIND_POP: begin
                     if (sts.empty) begin
                        cmd.set_under = 1'b1;
                     end else begin
                        cmd.pop = 1'b1;
                        if (sts.count_gt1) begin
                           cmd.idx_load_second = 1'b1;
                           state_in            = ST_FRONT_RD;
                        end
                     end
                  end
                  blse_pkg::KIND_MEMBER, blse_pkg::KIND_ERASE: begin
                     if (!sts.empty) begin
                        cmd.idx_load_top = 1'b1;
                        state_in         = ST_SRCH_RD;
                     end
                  end
                  blse_pkg::KIND_CLEAR: begin
                     cmd.clear = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SRCH_RD: begin
            cmd.mem_rd = 1'b1;
            state_in   = ST_SRCH_CMP;
         end
         ST_SRCH_CMP: begin
            if (sts.match) begin
               cmd.set_found = 1'b1;
               state_in      = ST_RESP;
               if (kind_ff == blse_pkg::KIND_ERASE) begin
                  if (sts.shift_more) begin
                     cmd.idx_inc = 1'b1;
                     state_in    = ST_SHIFT_RD;
                  end else begin
                     cmd.count_dec = 1'b1;
                     if (sts.count_gt1) begin
                        cmd.idx_load_second = 1'b1;
                        state_in            = ST_FRONT_RD;
                     end
                  end
               end
            end else if (sts.idx_zero) begin
               state_in = ST_RESP;
            end else begin
               cmd.idx_dec = 1'b1;
               state_in    = ST_SRCH_RD;
            end
         end
         ST_SHIFT_RD: begin
            cmd.mem_rd = 1'b1;
            state_in   = ST_SHIFT_WR;
         end
         ST_SHIFT_WR: begin
            cmd.shift_wr = 1'b1;
            if (sts.shift_more) begin
               cmd.idx_inc = 1'b1;
               state_in    = ST_SHIFT_RD;
            end else begin
               cmd.count_dec = 1'b1;
               state_in      = ST_RESP;
            end
         end
         ST_FRONT_RD: begin
            cmd.mem_rd = 1'b1;
            state_in   = ST_FRONT_LD;
         end
         ST_FRONT_LD: begin
            cmd.front_load = 1'b1;
            state_in       = ST_RESP;
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);

endmodule

FILE: rtl/core/bounded_list_with_search_erase_unit.sv
// Top level of the bounded list with push, pop, member test, erase and clear.
`timescale 1ns / 1ps
// Flow: push, clear, an unused kind, a pop that empties the list and a failing push or pop
// answer in the cycle after the item is taken; a pop that leaves entries reloads the front
// (ST_FRONT_RD, ST_FRONT_LD). Member test and erase read and compare one entry at a time
// from the top; erase then shifts each later entry down, or reloads an erased front entry.
// Throughput: one item at a time, busy from acceptance to the result cycle; no result stalls.
// Reset (synchronous, active high) empties the list and idles the controller; memory is kept.

module bounded_list_with_search_erase_unit #(
   parameter int DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [blse_pkg::KIND_W-1:0]         req_kind,
   input  logic signed [blse_pkg::DATA_W-1:0]  req_value,
   output logic                                rsp_valid,
   output logic signed [blse_pkg::DATA_W-1:0]  rsp_popped_value,
   output logic                                rsp_found,
   output logic [blse_pkg::STATUS_W-1:0]       rsp_status,
   output logic [blse_pkg::COUNT_OUT_W-1:0]    rsp_entry_count,
   output logic signed [blse_pkg::DATA_W-1:0]  rsp_front_value,
   output logic                                rsp_is_empty
);

   blse_pkg::dp_cmd_type cmd;
   blse_pkg::dp_sts_type sts;

   // The controller owns the sequence of each operation; the datapath holds the
   // list itself, with the front entry kept in a register so that a push or a
   // result never needs a memory read.
   blse_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_kind  (req_kind),
      .sts       (sts),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // Result fields come straight from datapath registers and are held stable
   // during the single result cycle.
   blse_datapath #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .req_value    (req_value),
      .popped_value (rsp_popped_value),
      .found        (rsp_found),
      .status       (rsp_status),
      .entry_count  (rsp_entry_count),
      .front_value  (rsp_front_value),
      .is_empty     (rsp_is_empty)
   );

   // An accepted item always makes the block busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset) (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   // The result strobe lasts exactly one cycle and the block is then idle.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !rsp_valid && !busy)
      else $error("result strobe longer than one cycle");

   // An empty list reports a zero front value.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_empty) |-> (rsp_front_value == '0))
      else $error("empty list with non-zero front value");

   // A failing push or pop never reports a found value.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != blse_pkg::STATUS_OK)) |-> !rsp_found)
      else $error("found flag set on a failed push or pop");

endmodule
